// ----- rtl/npgl_pkg.sv -----
// ----------------------------------------------------------------------------
// npgl_pkg
// Shared types and codes for the nearest-point grid lookup.
// ----------------------------------------------------------------------------
package npgl_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned IDENT_W = 16;
    localparam int unsigned STRIP_IN_W = 3;
    localparam int unsigned STRIP_W = 2;
    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned DIST_W = 33;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED   = 3'd0,
        ST_REJECTED = 3'd1,
        ST_IGNORED  = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } status_t;

    // One accepted transaction, classified by the front end
    typedef struct packed {
        logic                     is_query;
        logic                     do_store;
        logic                     do_build;
        status_t                  status;
        logic signed [COORD_W-1:0] lat;
        logic signed [COORD_W-1:0] lon;
        logic [IDENT_W-1:0]       ident;
        logic [STRIP_W-1:0]       strip;
        logic [PIXEL_W-1:0]       pixel;
    } cmd_t;

endpackage

// ----- rtl/npgl_ram.sv -----
// ----------------------------------------------------------------------------
// npgl_ram
// Single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module npgl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data <= mem[addr];
    end
endmodule

// ----- rtl/npgl_front.sv -----
// ----------------------------------------------------------------------------
// npgl_front
// Accepts requests, validates loads and tracks fill count and index state.
// ----------------------------------------------------------------------------
module npgl_front #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned STRIP_LIMIT = 4,
    parameter int unsigned PIXEL_LIMIT = 200
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic signed [npgl_pkg::COORD_W-1:0] lat_in,
    input  logic signed [npgl_pkg::COORD_W-1:0] lon_in,
    input  logic [npgl_pkg::IDENT_W-1:0]    ident_in,
    input  logic [npgl_pkg::STRIP_IN_W-1:0] strip_in,
    input  logic [npgl_pkg::PIXEL_W-1:0]    pixel_in,
    input  logic                             last_load,
    output logic                             cmd_valid,
    input  logic                             cmd_stall,
    output npgl_pkg::cmd_t                   cmd
);
    import npgl_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0] count_reg;
    logic             built_reg;
    logic             full_reg;
    cmd_t             cmd_reg;
    logic             accept;
    logic             bad;
    logic             store;

    assign in_stall  = full_reg;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;
    assign accept    = in_valid && !full_reg;

    assign bad = ({5'd0, strip_in} >= 8'(STRIP_LIMIT)) ||
                 ({1'b0, pixel_in} >= 9'(PIXEL_LIMIT)) ||
                 (count_reg >= CNT_W'(MAX_ENTRIES));
    assign store = !req_type && !built_reg && !bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            built_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            if (full_reg && !cmd_stall)
            begin
                full_reg <= 1'b0;
            end
            if (accept)
            begin
                full_reg <= 1'b1;
                if (store)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                if (!req_type && !built_reg && last_load)
                begin
                    built_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.is_query <= req_type;
            cmd_reg.do_store <= store;
            cmd_reg.do_build <= !req_type && !built_reg && last_load;
            if (req_type)
            begin
                cmd_reg.status <= built_reg ? ST_HIT : ST_MISS;
            end
            else if (built_reg)
            begin
                cmd_reg.status <= ST_IGNORED;
            end
            else
            begin
                cmd_reg.status <= bad ? ST_REJECTED : ST_LOADED;
            end
            cmd_reg.lat   <= lat_in;
            cmd_reg.lon   <= lon_in;
            cmd_reg.ident <= ident_in;
            cmd_reg.strip <= strip_in[STRIP_W-1:0];
            cmd_reg.pixel <= pixel_in;
        end
    end
endmodule

// ----- rtl/npgl_cell.sv -----
// ----------------------------------------------------------------------------
// npgl_cell
// Multi-cycle grid cell unit: trunc(d*(G-1)/r) clamped, by restoring division.
// ----------------------------------------------------------------------------
module npgl_cell #(
    parameter int unsigned GRID_CELLS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic signed [npgl_pkg::COORD_W-1:0] value,
    input  logic signed [npgl_pkg::COORD_W-1:0] lo,
    input  logic signed [npgl_pkg::COORD_W-1:0] hi,
    output logic        done,
    output logic [$clog2(GRID_CELLS)-1:0] cell_idx
);
    import npgl_pkg::*;

    localparam int unsigned CELL_W = $clog2(GRID_CELLS);
    localparam int unsigned GM1_W  = $clog2(GRID_CELLS);
    localparam int unsigned NUM_W  = COORD_W + 1 + GM1_W;
    localparam int unsigned DEN_W  = COORD_W + 1;
    localparam int unsigned STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W:0]    rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CELL_W-1:0] cell_reg;
    logic [DEN_W:0]    d_ext;
    logic [DEN_W:0]    r_ext;
    logic [DEN_W:0]    trial;
    logic              zero_out;

    assign d_ext = {{2{value[COORD_W-1]}}, value} - {{2{lo[COORD_W-1]}}, lo};
    assign r_ext = {{2{hi[COORD_W-1]}}, hi} - {{2{lo[COORD_W-1]}}, lo};
    assign zero_out = d_ext[DEN_W] || (d_ext == '0) || r_ext[DEN_W] || (r_ext == '0);
    assign trial = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
    assign done = done_reg;
    assign cell_idx = cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !zero_out;
                done_reg <= zero_out;
            end
            else if (busy_reg && step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= NUM_W'(d_ext[DEN_W-1:0]) * NUM_W'(GRID_CELLS - 1);
            den_reg  <= r_ext[DEN_W-1:0];
            rem_reg  <= '0;
            step_reg <= STEP_W'(NUM_W);
            cell_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                // num_reg now holds the quotient; clamp to the top cell
                if (num_reg > NUM_W'(GRID_CELLS - 1))
                begin
                    cell_reg <= CELL_W'(GRID_CELLS - 1);
                end
                else
                begin
                    cell_reg <= num_reg[CELL_W-1:0];
                end
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= trial - {1'b0, den_reg};
                    num_reg <= {num_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                end
            end
        end
    end
endmodule

// ----- rtl/npgl_back.sv -----
// ----------------------------------------------------------------------------
// npgl_back
// Executes stores, the index build and nearest-entry scans over the table.
// ----------------------------------------------------------------------------
module npgl_back #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned GRID_CELLS  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  npgl_pkg::cmd_t                cmd,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [npgl_pkg::STATUS_W-1:0] status,
    output logic [npgl_pkg::INDEX_W-1:0]  hit_index,
    output logic [npgl_pkg::IDENT_W-1:0]  hit_ident,
    output logic [npgl_pkg::STRIP_W-1:0]  hit_strip,
    output logic [npgl_pkg::PIXEL_W-1:0]  hit_pixel,
    output logic [npgl_pkg::DIST_W-1:0]   hit_dist_sq
);
    import npgl_pkg::*;

    localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
    localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CELL_W = $clog2(GRID_CELLS);
    localparam int unsigned SQ_W   = 2 * (COORD_W + 1);
    localparam int unsigned REC_W  = 2 * COORD_W + IDENT_W + STRIP_W + PIXEL_W;
    localparam int unsigned GEO_W  = 2 * CELL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_BOUND_RD, S_BOUND, S_CELL_RD, S_CELL_GO, S_CELL_WAIT,
        S_Q_LAT, S_Q_LON, S_SCAN_RD, S_SCAN_SQ, S_SCAN_CMP, S_OUT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic [CNT_W-1:0]  last_ptr_reg;
    logic              built_reg;
    logic signed [COORD_W-1:0] lat_lo_reg, lat_hi_reg, lon_lo_reg, lon_hi_reg;
    logic [CELL_W-1:0] row_reg, qrow_reg, qcol_reg;
    logic              axis_reg;
    logic [3:0]        nb_reg;
    cmd_t              cur_reg;
    logic              found_reg;
    logic [DIST_W-1:0] best_d_reg;
    logic [ADDR_W-1:0] best_i_reg;
    logic [REC_W-1:0]  best_rec_reg;
    logic [SQ_W-1:0]   sq_a_reg, sq_b_reg;
    logic              sq_in_reg;
    logic              ovalid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [IDENT_W-1:0]  ident_reg;
    logic [STRIP_W-1:0]  strip_reg;
    logic [PIXEL_W-1:0]  pixel_reg;
    logic [DIST_W-1:0]   dist_reg;

    logic              rec_we, geo_we;
    logic [ADDR_W-1:0] rec_addr, geo_addr;
    logic [REC_W-1:0]  rec_wdata, rec_rdata;
    logic [GEO_W-1:0]  geo_rdata;
    logic signed [COORD_W-1:0] e_lat, e_lon;

    logic              cu_start, cu_done;
    logic signed [COORD_W-1:0] cu_val, cu_lo, cu_hi;
    logic [CELL_W-1:0] cu_cell;

    logic signed [CELL_W+1:0] nr, nc;
    logic              nb_ok;
    logic signed [COORD_W:0] da, db;
    logic [DIST_W-1:0] dsum;

    assign e_lat = rec_rdata[REC_W-1 -: COORD_W];
    assign e_lon = rec_rdata[REC_W-1-COORD_W -: COORD_W];

    assign rec_we    = (state_reg == S_IDLE) && cmd_valid && !ovalid_reg && cmd.do_store;
    assign rec_wdata = {cmd.lat, cmd.lon, cmd.ident, cmd.strip, cmd.pixel};
    assign rec_addr  = (state_reg == S_IDLE) ? count_reg[ADDR_W-1:0] : ptr_reg[ADDR_W-1:0];
    assign geo_we    = (state_reg == S_CELL_WAIT) && axis_reg && cu_done;
    assign geo_addr  = ptr_reg[ADDR_W-1:0];

    npgl_ram #(.WIDTH(REC_W), .DEPTH(MAX_ENTRIES)) u_rec (
        .clk(clk), .wr_en(rec_we), .addr(rec_addr),
        .wr_data(rec_wdata), .rd_data(rec_rdata)
    );

    npgl_ram #(.WIDTH(GEO_W), .DEPTH(MAX_ENTRIES)) u_geo (
        .clk(clk), .wr_en(geo_we), .addr(geo_addr),
        .wr_data({row_reg, cu_cell}), .rd_data(geo_rdata)
    );

    always_comb
    begin
        cu_start = 1'b0;
        cu_val   = e_lat;
        cu_lo    = lat_lo_reg;
        cu_hi    = lat_hi_reg;
        unique case (state_reg)
            S_CELL_GO:
            begin
                cu_start = 1'b1;
                cu_val   = axis_reg ? e_lon : e_lat;
            end
            S_Q_LAT:
            begin
                cu_start = !axis_reg;
                cu_val   = cur_reg.lat;
            end
            S_Q_LON:
            begin
                cu_start = !axis_reg;
                cu_val   = cur_reg.lon;
            end
            default:
            begin
                cu_start = 1'b0;
            end
        endcase
        if (((state_reg == S_CELL_GO) && axis_reg) || (state_reg == S_Q_LON))
        begin
            cu_lo = lon_lo_reg;
            cu_hi = lon_hi_reg;
        end
    end

    npgl_cell #(.GRID_CELLS(GRID_CELLS)) u_cell (
        .clk(clk), .rst_n(rst_n), .start(cu_start), .value(cu_val),
        .lo(cu_lo), .hi(cu_hi), .done(cu_done), .cell_idx(cu_cell)
    );

    // neighbour cell from nb_reg: row offset outer, column offset inner
    always_comb
    begin
        logic [1:0] ro, co;
        ro = 2'd0;
        co = 2'd0;
        unique case (nb_reg)
            4'd0: begin ro = 2'd0; co = 2'd0; end
            4'd1: begin ro = 2'd0; co = 2'd1; end
            4'd2: begin ro = 2'd0; co = 2'd2; end
            4'd3: begin ro = 2'd1; co = 2'd0; end
            4'd4: begin ro = 2'd1; co = 2'd1; end
            4'd5: begin ro = 2'd1; co = 2'd2; end
            4'd6: begin ro = 2'd2; co = 2'd0; end
            4'd7: begin ro = 2'd2; co = 2'd1; end
            default: begin ro = 2'd2; co = 2'd2; end
        endcase
        nr = $signed({2'b00, qrow_reg}) + $signed((CELL_W+2)'(ro)) - (CELL_W+2)'(1);
        nc = $signed({2'b00, qcol_reg}) + $signed((CELL_W+2)'(co)) - (CELL_W+2)'(1);
        nb_ok = !nr[CELL_W+1] && (nr < (CELL_W+2)'(GRID_CELLS)) &&
                !nc[CELL_W+1] && (nc < (CELL_W+2)'(GRID_CELLS));
    end

    assign da   = (COORD_W+1)'(e_lat) - (COORD_W+1)'(cur_reg.lat);
    assign db   = (COORD_W+1)'(e_lon) - (COORD_W+1)'(cur_reg.lon);
    assign dsum = DIST_W'(sq_a_reg) + DIST_W'(sq_b_reg);

    assign cmd_stall   = !((state_reg == S_IDLE) && !ovalid_reg);
    assign out_valid   = ovalid_reg;
    assign status      = status_reg;
    assign hit_index   = index_reg;
    assign hit_ident   = ident_reg;
    assign hit_strip   = strip_reg;
    assign hit_pixel   = pixel_reg;
    assign hit_dist_sq = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            built_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && !ovalid_reg)
                    begin
                        cur_reg    <= cmd;
                        status_reg <= (cmd.is_query && !(built_reg && count_reg != '0))
                                      ? ST_MISS : cmd.status;
                        index_reg  <= cmd.do_store ? INDEX_W'(count_reg) : '0;
                        ident_reg  <= '0;
                        strip_reg  <= '0;
                        pixel_reg  <= '0;
                        dist_reg   <= '0;
                        found_reg  <= 1'b0;
                        ptr_reg    <= '0;
                        axis_reg   <= 1'b0;
                        nb_reg     <= '0;
                        sq_in_reg  <= 1'b0;
                        if (cmd.do_store)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (cmd.is_query)
                        begin
                            if (built_reg && count_reg != '0)
                            begin
                                state_reg <= S_Q_LAT;
                            end
                            else
                            begin
                                state_reg <= S_OUT;
                            end
                        end
                        else if (cmd.do_build)
                        begin
                            built_reg <= 1'b1;
                            lat_lo_reg <= '0;
                            lat_hi_reg <= '0;
                            lon_lo_reg <= '0;
                            lon_hi_reg <= '0;
                            last_ptr_reg <= count_reg + CNT_W'(cmd.do_store);
                            state_reg <= (count_reg + CNT_W'(cmd.do_store) == '0)
                                         ? S_OUT : S_BOUND_RD;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_BOUND_RD:
                begin
                    state_reg <= S_BOUND;
                end
                S_BOUND:
                begin
                    if (ptr_reg == '0 || e_lat < lat_lo_reg) lat_lo_reg <= e_lat;
                    if (ptr_reg == '0 || e_lat > lat_hi_reg) lat_hi_reg <= e_lat;
                    if (ptr_reg == '0 || e_lon < lon_lo_reg) lon_lo_reg <= e_lon;
                    if (ptr_reg == '0 || e_lon > lon_hi_reg) lon_hi_reg <= e_lon;
                    if (ptr_reg + 1'b1 == last_ptr_reg)
                    begin
                        ptr_reg   <= '0;
                        state_reg <= S_CELL_RD;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_BOUND_RD;
                    end
                end
                S_CELL_RD:
                begin
                    axis_reg  <= 1'b0;
                    state_reg <= S_CELL_GO;
                end
                S_CELL_GO:
                begin
                    state_reg <= S_CELL_WAIT;
                end
                S_CELL_WAIT:
                begin
                    if (cu_done)
                    begin
                        if (!axis_reg)
                        begin
                            row_reg   <= cu_cell;
                            axis_reg  <= 1'b1;
                            state_reg <= S_CELL_GO;
                        end
                        else if (ptr_reg + 1'b1 == last_ptr_reg)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg + 1'b1;
                            state_reg <= S_CELL_RD;
                        end
                    end
                end
                S_Q_LAT:
                begin
                    if (axis_reg && cu_done)
                    begin
                        qrow_reg  <= cu_cell;
                        axis_reg  <= 1'b0;
                        state_reg <= S_Q_LON;
                    end
                    else
                    begin
                        axis_reg <= 1'b1;
                    end
                end
                S_Q_LON:
                begin
                    axis_reg <= 1'b1;
                    if (axis_reg && cu_done)
                    begin
                        qcol_reg  <= cu_cell;
                        ptr_reg   <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_SQ;
                end
                S_SCAN_SQ:
                begin
                    sq_a_reg  <= SQ_W'(da * da);
                    sq_b_reg  <= SQ_W'(db * db);
                    sq_in_reg <= nb_ok && (geo_rdata == {nr[CELL_W-1:0], nc[CELL_W-1:0]});
                    state_reg <= S_SCAN_CMP;
                end
                S_SCAN_CMP:
                begin
                    if (sq_in_reg && (!found_reg || dsum < best_d_reg))
                    begin
                        found_reg    <= 1'b1;
                        best_d_reg   <= dsum;
                        best_i_reg   <= ptr_reg[ADDR_W-1:0];
                        best_rec_reg <= rec_rdata;
                    end
                    if (ptr_reg + 1'b1 == count_reg)
                    begin
                        ptr_reg <= '0;
                        if (nb_reg == 4'd8)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            nb_reg    <= nb_reg + 1'b1;
                            state_reg <= S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_OUT:
                begin
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_IDLE;
                    if (cur_reg.is_query && status_reg == ST_HIT)
                    begin
                        if (found_reg)
                        begin
                            index_reg <= INDEX_W'(best_i_reg);
                            ident_reg <= best_rec_reg[STRIP_W+PIXEL_W +: IDENT_W];
                            strip_reg <= best_rec_reg[PIXEL_W +: STRIP_W];
                            pixel_reg <= best_rec_reg[PIXEL_W-1:0];
                            dist_reg  <= best_d_reg;
                        end
                        else
                        begin
                            status_reg <= ST_MISS;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/nearest_point_grid_lookup.sv -----
// ----------------------------------------------------------------------------
// nearest_point_grid_lookup
// Nearest LED position lookup over a grid-indexed table.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries load and query transactions;
// output channel (out_valid / out_stall) returns one result per transaction.
// A transaction is taken when valid is high and stall is low.
// A front stage checks each load and holds one transaction for the back end,
// so a new transaction can be taken while the back end works or while a
// result waits on out_stall.
// A plain load passes through the front register and the back end's S_OUT
// state before out_valid rises. The load marking the end of the table builds
// the index: a bounding-box pass over the entries (S_BOUND_RD, S_BOUND), then
// two runs of the shared bit-serial divider per entry for its cells. A query
// needs two divider runs, then 9 passes over the table, each entry read on the
// single RAM port and taken through S_SCAN_RD, S_SCAN_SQ and S_SCAN_CMP.
// Reset empties the table and clears the index; the results of a stalled
// output are held until taken.
// ----------------------------------------------------------------------------
module nearest_point_grid_lookup #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned GRID_CELLS  = 32,
    parameter int unsigned STRIP_LIMIT = 4,
    parameter int unsigned PIXEL_LIMIT = 200
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic signed [npgl_pkg::COORD_W-1:0] lat_in,
    input  logic signed [npgl_pkg::COORD_W-1:0] lon_in,
    input  logic [npgl_pkg::IDENT_W-1:0]       ident_in,
    input  logic [npgl_pkg::STRIP_IN_W-1:0]    strip_in,
    input  logic [npgl_pkg::PIXEL_W-1:0]       pixel_in,
    input  logic                                last_load,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [npgl_pkg::STATUS_W-1:0]      status,
    output logic [npgl_pkg::INDEX_W-1:0]       hit_index,
    output logic [npgl_pkg::IDENT_W-1:0]       hit_ident,
    output logic [npgl_pkg::STRIP_W-1:0]       hit_strip,
    output logic [npgl_pkg::PIXEL_W-1:0]       hit_pixel,
    output logic [npgl_pkg::DIST_W-1:0]        hit_dist_sq
);
    import npgl_pkg::*;

    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;

    npgl_front #(
        .MAX_ENTRIES(MAX_ENTRIES), .STRIP_LIMIT(STRIP_LIMIT), .PIXEL_LIMIT(PIXEL_LIMIT)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .lat_in(lat_in), .lon_in(lon_in), .ident_in(ident_in),
        .strip_in(strip_in), .pixel_in(pixel_in), .last_load(last_load),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd)
    );

    npgl_back #(.MAX_ENTRIES(MAX_ENTRIES), .GRID_CELLS(GRID_CELLS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .cmd(cmd), .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .hit_index(hit_index), .hit_ident(hit_ident), .hit_strip(hit_strip),
        .hit_pixel(hit_pixel), .hit_dist_sq(hit_dist_sq)
    );
endmodule
